// ===== rtl/gmps_pkg.sv =====
// Shared widths, direction codes and control bundles for the grid max path sum block.
// No dependencies; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package gmps_pkg;

   localparam int MAX_GRID = 32;
   localparam int CELL_W   = 16;
   localparam int COL_W    = 5;
   localparam int GRID_W   = 6;
   localparam int SUM_W    = 24;
   localparam int DIR_W    = 2;
   localparam int ADDR_W   = 2 * COL_W;

   localparam logic [DIR_W-1:0] DIR_STRAIGHT = 2'd0;
   localparam logic [DIR_W-1:0] DIR_LEFT     = 2'd1;
   localparam logic [DIR_W-1:0] DIR_RIGHT    = 2'd2;

   // Row sum memory and predecessor window control
   typedef struct packed {
      logic             wr_en;
      logic             wr_bank;
      logic [COL_W-1:0] wr_col;
      logic             first_row;
      logic             single_col;
      logic             at_left;
      logic             at_right;
      logic             shift;
      logic             rd_en;
      logic             rd_bank;
      logic [COL_W-1:0] rd_col;
   } sum_ctrl_type;

   // Cell and direction memory control
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic              cell_rd_en;
      logic              dir_rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } mem_ctrl_type;

endpackage

`default_nettype wire

// ===== rtl/gmps_req_if.sv =====
// Input channel: one grid cell per transfer, valid/ready handshake.
// Depends on gmps_pkg for the cell width.
`timescale 1ns / 1ps
`default_nettype none

interface gmps_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [gmps_pkg::CELL_W-1:0] cell_value;

   modport source (output valid, output cell_value, input ready);
   modport sink (input valid, input cell_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/gmps_rsp_if.sv =====
// Result channel: one path row per transfer, valid/ready handshake.
// Depends on gmps_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface gmps_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [gmps_pkg::CELL_W-1:0] path_value;
   logic [gmps_pkg::COL_W-1:0]         path_column;
   logic signed [gmps_pkg::SUM_W-1:0]  path_total;
   logic                              path_last;

   modport source (output valid, output path_value, output path_column,
                   output path_total, output path_last, input ready);
   modport sink (input valid, input path_value, input path_column,
                 input path_total, input path_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/grid_max_path_sum_traceback.sv =====
// Grid max path sum with traceback.
// Cells stream in on req_bus in row-major order for an N x N grid, N set by
// csr_write_data (0 counts as 1, above 32 as 32); a csr write restarts the
// load at row 0, column 0. Within a row one cell is taken per cycle; each row
// after the first begins with ST_PRIME0 and ST_PRIME1, which prime the
// predecessor window from the row sum memory through its single read port.
// After the last cell, req_bus.ready drops: the bottom row is scanned for the
// first greatest sum, the path is traced back through the direction memory,
// then N results go out on rsp_bus, top row first, each read from the cell
// memory into the result register and held until taken. path_last marks
// the bottom row; path_total is the same in every result. While rsp_bus.ready
// is low the result register holds. The next grid is accepted after the last
// result transfer. Reset clears the load position and sets N to 32; memories
// are not cleared; every entry whose value is used is written for this grid.
// Depends on gmps_pkg, gmps_req_if, gmps_rsp_if, gmps_cell_mem, gmps_sum_path.
`timescale 1ns / 1ps
`default_nettype none

module grid_max_path_sum_traceback (
   input  wire logic                         clock,
   input  wire logic                         reset,
   gmps_req_if.sink                          req_bus,
   gmps_rsp_if.source                        rsp_bus,
   input  wire logic                         csr_write_en,
   input  wire logic [gmps_pkg::GRID_W-1:0]  csr_write_data
);

   localparam int COL_W  = gmps_pkg::COL_W;
   localparam int GRID_W = gmps_pkg::GRID_W;
   localparam int SUM_W  = gmps_pkg::SUM_W;
   localparam int CELL_W = gmps_pkg::CELL_W;
   localparam logic [GRID_W-1:0] MAX_N = GRID_W'(gmps_pkg::MAX_GRID);

   localparam logic [3:0] ST_LOAD     = 4'd0;
   localparam logic [3:0] ST_PRIME0   = 4'd1;
   localparam logic [3:0] ST_PRIME1   = 4'd2;
   localparam logic [3:0] ST_SCAN     = 4'd3;
   localparam logic [3:0] ST_TRACE_RD = 4'd4;
   localparam logic [3:0] ST_TRACE_UP = 4'd5;
   localparam logic [3:0] ST_OUT_RD   = 4'd6;
   localparam logic [3:0] ST_OUT_LD   = 4'd7;
   localparam logic [3:0] ST_OUT_WAIT = 4'd8;

   logic [3:0]              state_ff, state_in;
   logic [GRID_W-1:0]       grid_ff, grid_in;
   logic [COL_W-1:0]        row_ff, row_in;
   logic [COL_W-1:0]        col_ff, col_in;
   logic [GRID_W-1:0]       scan_ff, scan_in;
   logic [COL_W-1:0]        k_ff, k_in;
   logic [COL_W-1:0]        tcol_ff, tcol_in;
   logic [COL_W-1:0]        pcol_ff, pcol_in;
   logic signed [SUM_W-1:0] total_ff, total_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [CELL_W-1:0] rsp_value_ff;
   logic [COL_W-1:0]        rsp_column_ff;
   logic signed [SUM_W-1:0] rsp_total_ff;
   logic                    rsp_last_ff;
   logic [COL_W-1:0]        path_col_ff [gmps_pkg::MAX_GRID];

   logic [GRID_W-1:0]       n_eff;
   logic [COL_W-1:0]        last_col;
   logic                    req_accept;
   logic                    path_wr_en;
   logic                    rsp_load;
   logic [COL_W-1:0]        cmp_col;
   gmps_pkg::sum_ctrl_type  sum_ctrl;
   gmps_pkg::mem_ctrl_type  mem_ctrl;
   logic [gmps_pkg::DIR_W-1:0] new_dir;
   logic signed [SUM_W-1:0] rd_sum;
   logic signed [CELL_W-1:0] rd_cell;
   logic [gmps_pkg::DIR_W-1:0] rd_dir;

   gmps_sum_path u_sum_path (
      .clock      (clock),
      .ctrl       (sum_ctrl),
      .cell_value (req_bus.cell_value),
      .dir_out    (new_dir),
      .rd_sum     (rd_sum)
   );

   gmps_cell_mem u_cell_mem (
      .clock   (clock),
      .ctrl    (mem_ctrl),
      .wr_cell (req_bus.cell_value),
      .wr_dir  (new_dir),
      .rd_cell (rd_cell),
      .rd_dir  (rd_dir)
   );

   always_comb begin
      if (grid_ff == '0) begin
         n_eff = GRID_W'(1);
      end else if (grid_ff > MAX_N) begin
         n_eff = MAX_N;
      end else begin
         n_eff = grid_ff;
      end
   end

   assign last_col      = COL_W'(n_eff - GRID_W'(1));
   assign req_bus.ready = (state_ff == ST_LOAD);
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign cmp_col       = COL_W'(scan_ff - GRID_W'(1));

   always_comb begin
      state_in     = state_ff;
      grid_in      = grid_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      scan_in      = scan_ff;
      k_in         = k_ff;
      tcol_in      = tcol_ff;
      pcol_in      = pcol_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff;
      path_wr_en   = 1'b0;
      rsp_load     = 1'b0;
      sum_ctrl     = '0;
      mem_ctrl     = '0;

      unique case (state_ff)
         ST_LOAD: begin
            if (req_accept) begin
               sum_ctrl.wr_en      = 1'b1;
               sum_ctrl.wr_bank    = row_ff[0];
               sum_ctrl.wr_col     = col_ff;
               sum_ctrl.first_row  = (row_ff == '0);
               sum_ctrl.single_col = (n_eff == GRID_W'(1));
               sum_ctrl.at_left    = (col_ff == '0);
               sum_ctrl.at_right   = (col_ff == last_col);
               // Slide the window and fetch the predecessor two columns ahead
               sum_ctrl.shift      = 1'b1;
               sum_ctrl.rd_en      = 1'b1;
               sum_ctrl.rd_bank    = ~row_ff[0];
               sum_ctrl.rd_col     = col_ff + COL_W'(2);
               mem_ctrl.wr_en      = 1'b1;
               mem_ctrl.wr_addr    = {row_ff, col_ff};
               if (col_ff != last_col) begin
                  col_in = col_ff + COL_W'(1);
               end else begin
                  col_in = '0;
                  if (row_ff != last_col) begin
                     row_in   = row_ff + COL_W'(1);
                     state_in = ST_PRIME0;
                  end else begin
                     row_in   = '0;
                     scan_in  = '0;
                     state_in = ST_SCAN;
                  end
               end
            end
         end
         ST_PRIME0: begin
            sum_ctrl.rd_en   = 1'b1;
            sum_ctrl.rd_bank = ~row_ff[0];
            sum_ctrl.rd_col  = '0;
            state_in         = ST_PRIME1;
         end
         ST_PRIME1: begin
            sum_ctrl.shift   = 1'b1;
            sum_ctrl.rd_en   = 1'b1;
            sum_ctrl.rd_bank = ~row_ff[0];
            sum_ctrl.rd_col  = COL_W'(1);
            state_in         = ST_LOAD;
         end
         ST_SCAN: begin
            if (scan_ff < n_eff) begin
               sum_ctrl.rd_en   = 1'b1;
               sum_ctrl.rd_bank = last_col[0];
               sum_ctrl.rd_col  = scan_ff[COL_W-1:0];
            end
            // Compare the sum read on the previous cycle; keep the first maximum
            if (scan_ff != '0) begin
               if (cmp_col == '0 || rd_sum > total_ff) begin
                  total_in = rd_sum;
                  pcol_in  = cmp_col;
               end
            end
            scan_in = scan_ff + GRID_W'(1);
            if (scan_ff == n_eff) begin
               k_in     = last_col;
               tcol_in  = pcol_in;
               state_in = ST_TRACE_RD;
            end
         end
         ST_TRACE_RD: begin
            path_wr_en         = 1'b1;
            mem_ctrl.dir_rd_en = 1'b1;
            mem_ctrl.rd_addr   = {k_ff, tcol_ff};
            state_in           = ST_TRACE_UP;
         end
         ST_TRACE_UP: begin
            if (rd_dir == gmps_pkg::DIR_LEFT && tcol_ff != '0) begin
               tcol_in = tcol_ff - COL_W'(1);
            end else if (rd_dir == gmps_pkg::DIR_RIGHT && tcol_ff != last_col) begin
               tcol_in = tcol_ff + COL_W'(1);
            end
            if (k_ff == '0) begin
               state_in = ST_OUT_RD;
            end else begin
               k_in     = k_ff - COL_W'(1);
               state_in = ST_TRACE_RD;
            end
         end
         ST_OUT_RD: begin
            mem_ctrl.cell_rd_en = 1'b1;
            mem_ctrl.rd_addr    = {k_ff, path_col_ff[k_ff]};
            state_in            = ST_OUT_LD;
         end
         ST_OUT_LD: begin
            rsp_load     = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = ST_OUT_WAIT;
         end
         ST_OUT_WAIT: begin
            if (rsp_bus.ready) begin
               rsp_valid_in = 1'b0;
               if (k_ff == last_col) begin
                  state_in = ST_LOAD;
               end else begin
                  k_in     = k_ff + COL_W'(1);
                  state_in = ST_OUT_RD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase

      // Register write restarts the load
      if (csr_write_en) begin
         grid_in  = csr_write_data;
         row_in   = '0;
         col_in   = '0;
         state_in = ST_LOAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         grid_ff      <= MAX_N;
         row_ff       <= '0;
         col_ff       <= '0;
         scan_ff      <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         grid_ff      <= grid_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         scan_ff      <= scan_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tcol_ff  <= tcol_in;
      pcol_ff  <= pcol_in;
      total_ff <= total_in;
      if (path_wr_en) begin
         path_col_ff[k_ff] <= tcol_ff;
      end
      if (rsp_load) begin
         rsp_value_ff  <= rd_cell;
         rsp_column_ff <= path_col_ff[k_ff];
         rsp_total_ff  <= total_ff;
         rsp_last_ff   <= (k_ff == last_col);
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.path_value  = rsp_value_ff;
   assign rsp_bus.path_column = rsp_column_ff;
   assign rsp_bus.path_total  = rsp_total_ff;
   assign rsp_bus.path_last   = rsp_last_ff;

endmodule

`default_nettype wire

// ===== rtl/gmps_cell_mem.sv =====
// Cell value store and predecessor direction store, one entry per grid position.
// Depends on gmps_pkg for widths and the memory control bundle.
`timescale 1ns / 1ps
`default_nettype none

module gmps_cell_mem (
   input  wire logic                               clock,
   input  wire gmps_pkg::mem_ctrl_type             ctrl,
   input  wire logic signed [gmps_pkg::CELL_W-1:0] wr_cell,
   input  wire logic [gmps_pkg::DIR_W-1:0]         wr_dir,
   output logic signed [gmps_pkg::CELL_W-1:0]      rd_cell,
   output logic [gmps_pkg::DIR_W-1:0]              rd_dir
);

   localparam int DEPTH = gmps_pkg::MAX_GRID * gmps_pkg::MAX_GRID;

   logic signed [gmps_pkg::CELL_W-1:0] cell_mem [DEPTH];
   logic [gmps_pkg::DIR_W-1:0]         dir_mem [DEPTH];
   logic signed [gmps_pkg::CELL_W-1:0] rd_cell_ff;
   logic [gmps_pkg::DIR_W-1:0]         rd_dir_ff;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         cell_mem[ctrl.wr_addr] <= wr_cell;
         dir_mem[ctrl.wr_addr]  <= wr_dir;
      end
      if (ctrl.cell_rd_en) begin
         rd_cell_ff <= cell_mem[ctrl.rd_addr];
      end
      if (ctrl.dir_rd_en) begin
         rd_dir_ff <= dir_mem[ctrl.rd_addr];
      end
   end

   assign rd_cell = rd_cell_ff;
   assign rd_dir  = rd_dir_ff;

endmodule

`default_nettype wire

// ===== rtl/gmps_sum_path.sv =====
// Row sum memory (two banks by row parity), predecessor window and best-sum update.
// Depends on gmps_pkg for widths, direction codes and the sum control bundle.
`timescale 1ns / 1ps
`default_nettype none

module gmps_sum_path (
   input  wire logic                               clock,
   input  wire gmps_pkg::sum_ctrl_type             ctrl,
   input  wire logic signed [gmps_pkg::CELL_W-1:0] cell_value,
   output logic [gmps_pkg::DIR_W-1:0]              dir_out,
   output logic signed [gmps_pkg::SUM_W-1:0]       rd_sum
);

   localparam int SUM_W = gmps_pkg::SUM_W;
   localparam int CELL_W = gmps_pkg::CELL_W;
   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   logic signed [SUM_W-1:0] sum_mem [2 * gmps_pkg::MAX_GRID];
   logic signed [SUM_W-1:0] rd_sum_ff;
   logic signed [SUM_W-1:0] win_l_ff;
   logic signed [SUM_W-1:0] win_s_ff;
   logic signed [SUM_W-1:0] best;
   logic signed [SUM_W:0]   wide;
   logic signed [SUM_W-1:0] new_sum;
   logic [gmps_pkg::DIR_W-1:0] dir;

   // Window: win_l = left, win_s = straight, rd_sum_ff = right predecessor
   always_comb begin
      best = win_s_ff;
      dir  = gmps_pkg::DIR_STRAIGHT;
      if (ctrl.first_row || ctrl.single_col) begin
         best = win_s_ff;
         dir  = gmps_pkg::DIR_STRAIGHT;
      end else if (ctrl.at_left) begin
         if (rd_sum_ff > best) begin
            best = rd_sum_ff;
            dir  = gmps_pkg::DIR_RIGHT;
         end
      end else if (ctrl.at_right) begin
         if (win_l_ff > best) begin
            best = win_l_ff;
            dir  = gmps_pkg::DIR_LEFT;
         end
      end else begin
         best = win_l_ff;
         dir  = gmps_pkg::DIR_LEFT;
         if (win_s_ff > best) begin
            best = win_s_ff;
            dir  = gmps_pkg::DIR_STRAIGHT;
         end
         if (rd_sum_ff > best) begin
            best = rd_sum_ff;
            dir  = gmps_pkg::DIR_RIGHT;
         end
      end
      if (ctrl.first_row) begin
         best = '0;
      end
      wide = {best[SUM_W-1], best} +
             {{(SUM_W+1-CELL_W){cell_value[CELL_W-1]}}, cell_value};
      // Clamp to the signed sum range on overflow
      if (wide[SUM_W] != wide[SUM_W-1]) begin
         new_sum = wide[SUM_W] ? SUM_MIN : SUM_MAX;
      end else begin
         new_sum = wide[SUM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         sum_mem[{ctrl.wr_bank, ctrl.wr_col}] <= new_sum;
      end
      if (ctrl.rd_en) begin
         rd_sum_ff <= sum_mem[{ctrl.rd_bank, ctrl.rd_col}];
      end
      if (ctrl.shift) begin
         win_l_ff <= win_s_ff;
         win_s_ff <= rd_sum_ff;
      end
   end

   assign dir_out = dir;
   assign rd_sum  = rd_sum_ff;

endmodule

`default_nettype wire

// ===== dv/grid_max_path_sum_traceback_tb.sv =====
// Self-checking testbench for grid_max_path_sum_traceback: streams grids of cells, predicts
// each traced path in SystemVerilog and compares every result row field by field.
// Depends on gmps_pkg, gmps_req_if, gmps_rsp_if and the block itself.
`timescale 1ns / 1ps

module grid_max_path_sum_traceback_tb;

   localparam int MAX_GRID = gmps_pkg::MAX_GRID;
   localparam int CELL_W   = gmps_pkg::CELL_W;
   localparam int COL_W    = gmps_pkg::COL_W;
   localparam int GRID_W   = gmps_pkg::GRID_W;
   localparam int SUM_W    = gmps_pkg::SUM_W;
   localparam int DIR_W    = gmps_pkg::DIR_W;
   localparam logic [DIR_W-1:0] DIR_STRAIGHT = gmps_pkg::DIR_STRAIGHT;
   localparam logic [DIR_W-1:0] DIR_LEFT     = gmps_pkg::DIR_LEFT;
   localparam logic [DIR_W-1:0] DIR_RIGHT    = gmps_pkg::DIR_RIGHT;

   localparam int STALL_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 24;
   localparam int RANDOM_CELLS  = 140;
   localparam int STIM_ROWS     = 19;

   typedef struct packed {
      logic                     do_cfg;
      logic [GRID_W-1:0]        cfg;
      logic signed [CELL_W-1:0] stim_value;
      logic [10:0]              reps;
      logic                     typed;
      logic signed [CELL_W-1:0] e_value;
      logic [COL_W-1:0]         e_col;
      logic signed [SUM_W-1:0]  e_total;
   } stim_row_type;

   typedef struct packed {
      logic signed [CELL_W-1:0] value;
      logic [COL_W-1:0]         column;
      logic signed [SUM_W-1:0]  total;
      logic                     last;
   } path_row_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_write_en;
   logic [GRID_W-1:0] csr_write_data;

   gmps_req_if req_bus ();
   gmps_rsp_if rsp_bus ();

   grid_max_path_sum_traceback u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   // Predictor copy of the grid, chosen directions and the two row sum banks
   logic signed [CELL_W-1:0] cell_copy [MAX_GRID*MAX_GRID];
   logic [DIR_W-1:0]         step_dir [MAX_GRID*MAX_GRID];
   logic signed [SUM_W-1:0]  best_sum [2*MAX_GRID];
   int                       load_r;
   int                       load_c;
   logic [GRID_W-1:0]        grid_cfg;

   path_row_type traced_rows [$];
   path_row_type expected_path [$];
   path_row_type want;

   int errors = 0;
   int rows_checked = 0;
   int cells_sent = 0;
   int grids_done = 0;
   int stall_cycles = 0;
   int cycle_count = 0;
   int rsp_hold = 0;
   bit quiet = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int grid_span();
      if (grid_cfg < 1) return 1;
      if (grid_cfg > MAX_GRID) return MAX_GRID;
      return int'(grid_cfg);
   endfunction

   function automatic int clamp_sum(longint s);
      if (s > 64'sd8388607) return 8388607;
      if (s < -64'sd8388608) return -8388608;
      return int'(s);
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 45);
   endfunction

   function automatic logic signed [CELL_W-1:0] rand_cell();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4) return CELL_W'($urandom);
      // narrow values make ties common
      if (r < 8) return CELL_W'($urandom_range(0, 4)) - CELL_W'(2);
      case ($urandom_range(0, 3))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return 16'sh0000;
         default: return 16'shFFFF;
      endcase
   endfunction

   // Directed stimulus; typed expectations only where the path is obvious
   function automatic stim_row_type stim_at(int i);
      case (i)
         0: begin
            // reset size of 32: load into the second row, abandoned by the next size write
            return '{1'b0, 6'd0, 16'sh8000, 11'd40, 1'b0, 16'sd0, 5'd0, 24'sd0};
         end
         1:  return '{1'b1, 6'd1,  16'sh7FFF, 11'd1, 1'b1, 16'sh7FFF, 5'd0, 24'sh007FFF};
         2:  return '{1'b0, 6'd0,  16'sh8000, 11'd1, 1'b1, 16'sh8000, 5'd0, 24'shFF8000};
         3:  return '{1'b1, 6'd0,  16'sh0000, 11'd1, 1'b1, 16'sh0000, 5'd0, 24'sh000000};
         4:  return '{1'b0, 6'd0,  16'shFFFF, 11'd1, 1'b1, 16'shFFFF, 5'd0, 24'shFFFFFF};
         5:  return '{1'b1, 6'd2,  16'sd100,  11'd4, 1'b0, 16'sd0, 5'd0, 24'sd0};
         6:  return '{1'b1, 6'd3,  16'sd100,  11'd9, 1'b0, 16'sd0, 5'd0, 24'sd0};
         7:  return '{1'b1, 6'd3,  16'sd1,    11'd1, 1'b0, 16'sd0, 5'd0, 24'sd0};
         8:  return '{1'b0, 6'd0,  16'sd9,    11'd1, 1'b0, 16'sd0, 5'd0, 24'sd0};
         9:  return '{1'b0, 6'd0,  16'sd1,    11'd1, 1'b0, 16'sd0, 5'd0, 24'sd0};
         10: return '{1'b0, 6'd0,  16'sd9,    11'd1, 1'b0, 16'sd0, 5'd0, 24'sd0};
         11: return '{1'b0, 6'd0,  16'sd1,    11'd1, 1'b0, 16'sd0, 5'd0, 24'sd0};
         12: return '{1'b0, 6'd0,  16'sd1,    11'd1, 1'b0, 16'sd0, 5'd0, 24'sd0};
         13: return '{1'b0, 6'd0,  16'sd1,    11'd1, 1'b0, 16'sd0, 5'd0, 24'sd0};
         14: return '{1'b0, 6'd0,  16'sd1,    11'd1, 1'b0, 16'sd0, 5'd0, 24'sd0};
         15: return '{1'b0, 6'd0,  16'sd9,    11'd1, 1'b0, 16'sd0, 5'd0, 24'sd0};
         // partial grid, abandoned by the size write of the next row
         16: return '{1'b1, 6'd3,  16'sd5,    11'd2, 1'b0, 16'sd0, 5'd0, 24'sd0};
         17: return '{1'b1, 6'd1,  16'sd5,    11'd1, 1'b1, 16'sd5, 5'd0, 24'sd5};
         18: return '{1'b1, 6'd2,  16'sh7FFF, 11'd4, 1'b0, 16'sd0, 5'd0, 24'sd0};
         default: return '0;
      endcase
   endfunction

   // Fold one cell into the predictor; on the last cell of a grid, queue the traced path
   task automatic trace_cell(input logic signed [CELL_W-1:0] v);
      int n, r, c, cur, prv, best, k, col, total;
      logic [DIR_W-1:0] d;
      int path_col [MAX_GRID];
      path_row_type pr;
      n = grid_span();
      r = load_r;
      c = load_c;
      cur = (r % 2) * MAX_GRID;
      prv = ((r + 1) % 2) * MAX_GRID;
      d = DIR_STRAIGHT;
      cell_copy[r*MAX_GRID+c] = v;
      if (r == 0) begin
         best_sum[cur+c] = SUM_W'(clamp_sum(longint'(v)));
      end else begin
         best = best_sum[prv+c];
         // a single column only ever looks straight up
         if (n > 1) begin
            if (c == 0) begin
               if (best_sum[prv+1] > best) begin
                  best = best_sum[prv+1];
                  d = DIR_RIGHT;
               end
            end else if (c == n - 1) begin
               if (best_sum[prv+c-1] > best) begin
                  best = best_sum[prv+c-1];
                  d = DIR_LEFT;
               end
            end else begin
               best = best_sum[prv+c-1];
               d = DIR_LEFT;
               if (best_sum[prv+c] > best) begin
                  best = best_sum[prv+c];
                  d = DIR_STRAIGHT;
               end
               if (best_sum[prv+c+1] > best) begin
                  best = best_sum[prv+c+1];
                  d = DIR_RIGHT;
               end
            end
         end
         best_sum[cur+c] = SUM_W'(clamp_sum(longint'(best) + longint'(v)));
      end
      step_dir[r*MAX_GRID+c] = d;
      if (c + 1 < n) begin
         load_c = c + 1;
         return;
      end
      load_c = 0;
      if (r + 1 < n) begin
         load_r = r + 1;
         return;
      end
      load_r = 0;
      col = 0;
      total = best_sum[cur];
      for (k = 1; k < n; k++) begin
         if (best_sum[cur+k] > total) begin
            total = best_sum[cur+k];
            col = k;
         end
      end
      for (k = n - 1; k >= 0; k--) begin
         path_col[k] = col;
         d = step_dir[k*MAX_GRID+col];
         if (d == DIR_LEFT && col > 0) col--;
         else if (d == DIR_RIGHT && col + 1 < n) col++;
      end
      for (k = 0; k < n; k++) begin
         pr.value = cell_copy[k*MAX_GRID+path_col[k]];
         pr.column = COL_W'(path_col[k]);
         pr.total = SUM_W'(total);
         pr.last = (k == n - 1);
         traced_rows.push_back(pr);
      end
      grids_done++;
   endtask

   task automatic send_cell(input logic signed [CELL_W-1:0] v, input bit use_pinned,
                            input path_row_type pinned);
      int gap;
      path_row_type pr;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.cell_value <= v;
      do @(posedge clock); while (!req_bus.ready);
      cells_sent++;
      trace_cell(v);
      while (traced_rows.size() > 0) begin
         pr = traced_rows.pop_front();
         if (use_pinned) begin
            pr.value = pinned.value;
            pr.column = pinned.column;
            pr.total = pinned.total;
         end
         expected_path.push_back(pr);
      end
   endtask

   // Write the size only once the block has drained and settled
   task automatic set_grid_size(input logic [GRID_W-1:0] size);
      req_bus.valid <= 1'b0;
      while (expected_path.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_write_data <= size;
      @(posedge clock);
      csr_write_en <= 1'b0;
      grid_cfg = size;
      load_r = 0;
      load_c = 0;
   endtask

   // Receiver stalls; quiet stretches drop them
   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold--;
      end else begin
         rsp_bus.ready <= 1'b1;
         if ($urandom_range(0, 99) < 30) rsp_hold = pick_gap();
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_path.size() == 0) begin
            $error("unexpected result transfer: path_value %0d, path_column %0d",
                   rsp_bus.path_value, rsp_bus.path_column);
            errors++;
         end else begin
            want = expected_path.pop_front();
            rows_checked++;
            if (rsp_bus.path_value !== want.value) begin
               $error("path_value: expected %0d, got %0d", want.value, rsp_bus.path_value);
               errors++;
            end
            if (rsp_bus.path_column !== want.column) begin
               $error("path_column: expected %0d, got %0d", want.column, rsp_bus.path_column);
               errors++;
            end
            if (rsp_bus.path_total !== want.total) begin
               $error("path_total: expected %0d, got %0d", want.total, rsp_bus.path_total);
               errors++;
            end
            if (rsp_bus.path_last !== want.last) begin
               $error("path_last: expected %0d, got %0d", want.last, rsp_bus.path_last);
               errors++;
            end
         end
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count % 400 == 0) quiet <= ($urandom_range(0, 2) == 0);
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          csr_write_en) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     stall_cycles, expected_path.size());
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      int i, k, n, count, random_cells, r;
      bit need_cfg;
      stim_row_type row;
      path_row_type pinned;
      logic [GRID_W-1:0] sz;

      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_write_data = '0;
      req_bus.valid = 1'b0;
      req_bus.cell_value = '0;
      for (i = 0; i < MAX_GRID*MAX_GRID; i++) begin
         cell_copy[i] = '0;
         step_dir[i] = DIR_STRAIGHT;
      end
      for (i = 0; i < 2*MAX_GRID; i++) best_sum[i] = '0;
      grid_cfg = GRID_W'(MAX_GRID);
      load_r = 0;
      load_c = 0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < STIM_ROWS; i++) begin
         row = stim_at(i);
         if (row.do_cfg) set_grid_size(row.cfg);
         pinned = '{row.e_value, row.e_col, row.e_total, 1'b0};
         for (k = 0; k < row.reps; k++) send_cell(row.stim_value, row.typed, pinned);
      end

      // Mostly small grids, the zero setting now and then
      random_cells = 0;
      need_cfg = 1'b1;
      while (random_cells < RANDOM_CELLS) begin
         if (need_cfg || $urandom_range(0, 1) == 1) begin
            r = $urandom_range(0, 99);
            if (r < 8) sz = 6'd0;
            else if (r < 80) sz = GRID_W'($urandom_range(1, 6));
            else sz = GRID_W'($urandom_range(7, 12));
            set_grid_size(sz);
         end
         n = grid_span();
         count = n * n;
         // now and then abandon a grid partway through
         if (n > 1 && $urandom_range(0, 7) == 0) count = $urandom_range(1, n * n - 1);
         need_cfg = (count != n * n);
         for (k = 0; k < count; k++) begin
            send_cell(rand_cell(), 1'b0, '0);
            random_cells++;
         end
      end

      req_bus.valid <= 1'b0;
      while (expected_path.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("%0d cells streamed, %0d grids traced (sizes 1 to 12, zero setting, cut grids)",
               cells_sent, grids_done);
      $display("%0d path rows compared, %0d mismatches", rows_checked, errors);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
